@@ sv/sorttab_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table package
// Word types, status codes, controller states and the control bundle that the
// controller broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package sorttab_pkg;

  // Request kinds.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DELETED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Input word.
  typedef struct packed {
    logic              req_type;
    logic signed [31:0] value;
  } in_word_t;

  // Result word.
  typedef struct packed {
    status_t           status;
    logic [6:0]        count_after;
    logic signed [31:0] smallest;
    logic signed [31:0] largest;
  } out_word_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY,
    S_EMIT
  } state_t;

  // Control broadcast to all cells.
  typedef struct packed {
    logic              load;
    logic              apply;
    logic              is_del;
    logic signed [31:0] value;
  } cell_ctl_t;

endpackage

@@ sv/sorttab_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table cell
// Holds one table entry. On a load it compares its entry with the request
// value and keeps the result; on an apply it either keeps its entry, takes
// the new value, or takes a neighbor's entry so that the row shifts by one.
// ----------------------------------------------------------------------------
module sorttab_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sorttab_pkg::cell_ctl_t ctl,
  input  logic                   valid,
  input  logic signed [31:0]     left_data,
  input  logic                   left_ge,
  input  logic signed [31:0]     right_data,
  output logic signed [31:0]     data,
  output logic                   ge,
  output logic                   eq
);
  import sorttab_pkg::*;

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;
  logic               ge_r;
  logic               eq_r;

  // Compare flags. For an insert the cell is at or past the insertion point
  // when it is empty or holds a strictly greater entry; for a delete when it
  // is empty or holds an entry not less than the value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ge_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (ctl.load) begin
      ge_r <= !valid || (ctl.is_del ? (data_r >= ctl.value) : (data_r > ctl.value));
      eq_r <= valid && (data_r == ctl.value);
    end
  end

  // Next entry: deletes pull from the right, inserts push to the right.
  always_comb begin
    data_nxt = data_r;
    if (ctl.is_del) begin
      if (ge_r) begin
        data_nxt = right_data;
      end
    end else if (left_ge) begin
      data_nxt = left_data;
    end else if (ge_r) begin
      data_nxt = ctl.value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      data_r <= data_nxt;
    end
  end

  assign data = data_r;
  assign ge   = ge_r;
  assign eq   = eq_r;

endmodule

@@ sv/sorted_table_insert_delete_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table insert/delete
// Keeps up to CAPACITY signed entries in ascending order in a row of cells.
// ----------------------------------------------------------------------------
// In the cycle a request word is accepted every cell compares its entry with
// the value, in the next cycle the row shifts by one
// place at once (right for an insert, left for a delete), and the result word
// is then loaded from the updated cells while the next request is accepted.
// No new request is therefore taken while one is being applied, and a stalled
// result holds off the next request only once the finished result has nowhere
// to go. Inserts go after equal entries, deletes remove the frontmost equal
// entry, and an insert into a full table is refused with a full status.
// Entries above the count are never reported.
module sorted_table_insert_delete_top #(
  parameter int CAPACITY = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  sorttab_pkg::in_word_t  in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output sorttab_pkg::out_word_t out_data
);
  import sorttab_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  state_t             state_r;
  state_t             state_nxt;
  in_word_t           req_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  status_t            status_r;
  status_t            status_nxt;
  logic               out_valid_r;
  out_word_t          out_data_r;
  logic               out_free;
  logic               in_accept;
  logic               found;
  logic               full;
  logic               do_update;
  cell_ctl_t          ctl;
  logic [CW+6:0]      count_ext;
  logic signed [31:0] largest;

  logic signed [31:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_ge;
  logic [CAPACITY-1:0] cell_eq;
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_last;

  // Handshake.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) || ((state_r == S_EMIT) && out_free));
  assign in_accept = in_valid && !in_stall;

  // Request holding register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r <= in_data;
    end
  end

  // Decision for the apply cycle.
  assign found     = |cell_eq;
  assign full      = (count_r == CW'(CAPACITY));
  assign do_update = (req_r.req_type == REQ_DELETE) ? found : !full;

  // Broadcast to the cells.
  always_comb begin
    ctl.load   = in_accept;
    ctl.apply  = (state_r == S_APPLY) && do_update;
    ctl.is_del = in_accept ? (in_data.req_type == REQ_DELETE)
                           : (req_r.req_type == REQ_DELETE);
    ctl.value  = in_accept ? in_data.value : req_r.value;
  end

  // Controller next state, status and count.
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        state_nxt = S_EMIT;
        if (req_r.req_type == REQ_DELETE) begin
          status_nxt = found ? ST_DELETED : ST_NOT_FOUND;
          if (found) begin
            count_nxt = count_r - CW'(1);
          end
        end else begin
          status_nxt = full ? ST_FULL : ST_INSERTED;
          if (!full) begin
            count_nxt = count_r + CW'(1);
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = in_accept ? S_APPLY : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      status_r <= ST_INSERTED;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
    end
  end

  // The chain of cells.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_data;
    logic               left_ge;
    logic signed [31:0] right_data;

    assign cell_valid[i] = (count_r > CW'(i));

    if (i == 0) begin : g_first
      assign left_data = '0;
      assign left_ge   = 1'b0;
    end else begin : g_inner
      assign left_data = cell_data[i-1];
      assign left_ge   = cell_ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_data   = '0;
      assign cell_last[i] = cell_valid[i];
    end else begin : g_mid
      assign right_data   = cell_data[i+1];
      assign cell_last[i] = cell_valid[i] && !cell_valid[i+1];
    end

    sorttab_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .valid      (cell_valid[i]),
      .left_data  (left_data),
      .left_ge    (left_ge),
      .right_data (right_data),
      .data       (cell_data[i]),
      .ge         (cell_ge[i]),
      .eq         (cell_eq[i])
    );
  end

  // Rear entry: the one cell that is the last valid one, zero when empty.
  always_comb begin
    largest = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      largest = largest | (cell_last[i] ? cell_data[i] : 32'sd0);
    end
  end

  assign count_ext = {7'd0, count_r};

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_EMIT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_EMIT) && out_free) begin
      out_data_r.status      <= status_r;
      out_data_r.count_after <= count_ext[6:0];
      out_data_r.smallest    <= cell_valid[0] ? cell_data[0] : 32'sd0;
      out_data_r.largest     <= largest;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The count never runs past the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // An apply cycle is always followed by the result cycle.
  a_apply_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_APPLY |=> state_r == S_EMIT)
    else $error("apply not followed by emit");

  // The count moves by at most one, and only in an apply cycle.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_APPLY |=> count_r == $past(count_r))
    else $error("count changed outside apply");

  // A new result word comes only from the emit state.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_EMIT)
    else $error("result word without emit");

endmodule
